// File: sv/iefq_pkg.sv
package iefq_pkg;

   // Default geometry of the packet ring
   localparam int PACKET_EVENTS_DEFAULT = 8;
   localparam int RING_SLOTS_DEFAULT    = 16;

   // Field widths of one event
   localparam int EVENT_FIELD_WIDTH = 16;
   localparam int VALUE_WIDTH       = 32;
   localparam int SECONDS_WIDTH     = 32;
   localparam int MICROS_WIDTH      = 20;
   localparam int SIZE_WIDTH        = 4;
   localparam int EVENT_BITS        = 2 * EVENT_FIELD_WIDTH + VALUE_WIDTH + SECONDS_WIDTH
                                      + MICROS_WIDTH;

   // Stream payload widths
   localparam int REQ_DATA_WIDTH = ((EVENT_BITS + 7) / 8) * 8;
   localparam int REQ_USER_WIDTH = 3;
   localparam int RSP_DATA_WIDTH = ((EVENT_BITS + SIZE_WIDTH + 7) / 8) * 8;
   localparam int RSP_USER_WIDTH = 2;

   // Sync report marker
   localparam logic [EVENT_FIELD_WIDTH-1:0] EV_SYN    = 16'd0;
   localparam logic [EVENT_FIELD_WIDTH-1:0] SYNC_CODE = 16'd0;

   // Request operations
   localparam logic OP_EVENT = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_EVENT    = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_SHUTDOWN = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COUNT,
      ST_FETCH,
      ST_SEND,
      ST_SINGLE
   } state_type;

endpackage

// File: sv/input_event_frame_queue.sv
// Input event packet queue. Event requests (tuser bit 0 low) from the watched device that are
// not injected are appended to the packet under assembly while capture is on; a sync report
// (type 0, code 0) or a full packet commits it to a ring of RING_SLOTS slots, which holds up to
// RING_SLOTS-1 packets and drops its oldest packet when a commit finds it full. A read request
// pops the oldest packet and returns its events as a run ending in tlast: ST_IDLE accepts it,
// ST_COUNT looks up the slot's event count, then ST_FETCH reads each event from memory and
// ST_SEND registers it, waiting while the output is stalled. A read of an empty ring returns
// one result with status 1 (capture on) or 2 (capture off) through ST_SINGLE. Requests are
// taken only while no read is in progress. Writing csr_wr_data = 1 starts capture and clears
// the ring; writing 0 stops capture and keeps queued packets readable.
module input_event_frame_queue #(
   parameter int PACKET_EVENTS = iefq_pkg::PACKET_EVENTS_DEFAULT,
   parameter int RING_SLOTS    = iefq_pkg::RING_SLOTS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_wr_en,
   input  logic                                csr_wr_data,   // capture_enable
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // event_type, event_code, event_value, stamp_seconds, stamp_micros, zero pad
   input  logic [iefq_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   // operation, from_target, injected
   input  logic [iefq_pkg::REQ_USER_WIDTH-1:0] req_tuser,
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_type, out_code, out_value, out_seconds, out_micros, packet_size
   output logic [iefq_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // status
   output logic [iefq_pkg::RSP_USER_WIDTH-1:0] rsp_tuser,
   output logic                                rsp_tlast
);
   import iefq_pkg::*;

   localparam int CW        = $clog2(PACKET_EVENTS + 1);
   localparam int EW        = (PACKET_EVENTS > 1) ? $clog2(PACKET_EVENTS) : 1;
   localparam int SW        = $clog2(RING_SLOTS);
   localparam int EV_DEPTH  = RING_SLOTS * (2 ** EW);
   localparam int EV_AW     = SW + EW;

   // Storage
   logic [EVENT_BITS-1:0] ev_mem [EV_DEPTH];
   logic [CW-1:0]         cnt_mem [RING_SLOTS];

   // Control registers
   state_type  state_ff, state_in;
   logic       capture_ff, capture_in;
   logic [SW-1:0] write_slot_ff, write_slot_in;
   logic [SW-1:0] read_slot_ff, read_slot_in;
   logic [SW-1:0] rd_slot_ff, rd_slot_in;
   logic [CW-1:0] asm_cnt_ff, asm_cnt_in;
   logic [CW-1:0] pkt_cnt_ff, pkt_cnt_in;
   logic [CW-1:0] idx_ff, idx_in;
   status_type single_status_ff, single_status_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Response payload registers
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic                      rsp_last_ff, rsp_last_in;

   // Memory ports
   logic                  ev_we;
   logic [EV_AW-1:0]      ev_waddr;
   logic                  ev_re;
   logic [EV_AW-1:0]      ev_raddr;
   logic [EVENT_BITS-1:0] ev_rd_ff;
   logic                  cnt_we;
   logic [CW-1:0]         cnt_wdata;
   logic [CW-1:0]         cnt_rd_ff;

   // Combinational helpers
   logic          out_free;
   logic          taken;
   logic          is_sync;
   logic [CW-1:0] new_cnt;
   logic [SW-1:0] write_next;
   logic [SW-1:0] read_next;
   logic          last_event;
   logic [CW+SIZE_WIDTH-1:0] cnt_ext;

   function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
      next_slot = (s == SW'(RING_SLOTS - 1)) ? '0 : s + SW'(1);
   endfunction

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign taken      = capture_ff && req_tuser[1] && !req_tuser[2];
   assign is_sync    = (req_tdata[EVENT_FIELD_WIDTH-1:0] == EV_SYN) &&
                       (req_tdata[2*EVENT_FIELD_WIDTH-1:EVENT_FIELD_WIDTH] == SYNC_CODE);
   assign new_cnt    = asm_cnt_ff + CW'(1);
   assign write_next = next_slot(write_slot_ff);
   assign read_next  = next_slot(read_slot_ff);
   assign last_event = (idx_ff + CW'(1)) == pkt_cnt_ff;
   assign cnt_ext    = (CW + SIZE_WIDTH)'(pkt_cnt_ff);
   assign ev_waddr   = {write_slot_ff, asm_cnt_ff[EW-1:0]};
   assign ev_raddr   = {rd_slot_ff, idx_ff[EW-1:0]};
   assign cnt_wdata  = new_cnt;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Event memory: write a new event, read one event of the popped packet
   always_ff @(posedge clock) begin
      if (ev_we) begin
         ev_mem[ev_waddr] <= req_tdata[EVENT_BITS-1:0];
      end
      if (ev_re) begin
         ev_rd_ff <= ev_mem[ev_raddr];
      end
   end

   // Count memory: write on commit, read the oldest slot every cycle
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[write_slot_ff] <= cnt_wdata;
      end
      cnt_rd_ff <= cnt_mem[read_slot_ff];
   end

   // Next state and datapath control
   always_comb begin
      state_in         = state_ff;
      capture_in       = capture_ff;
      write_slot_in    = write_slot_ff;
      read_slot_in     = read_slot_ff;
      rd_slot_in       = rd_slot_ff;
      asm_cnt_in       = asm_cnt_ff;
      pkt_cnt_in       = pkt_cnt_ff;
      idx_in           = idx_ff;
      single_status_in = single_status_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_last_in      = rsp_last_ff;
      ev_we            = 1'b0;
      ev_re            = 1'b0;
      cnt_we           = 1'b0;

      // drop the response once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser[0] == OP_EVENT) begin
                  // append, and commit on sync report or full packet
                  if (taken) begin
                     ev_we = 1'b1;
                     if (is_sync || new_cnt == CW'(PACKET_EVENTS)) begin
                        cnt_we        = 1'b1;
                        write_slot_in = write_next;
                        asm_cnt_in    = '0;
                        if (write_next == read_slot_ff) begin
                           read_slot_in = read_next;
                        end
                     end else begin
                        asm_cnt_in = new_cnt;
                     end
                  end
               end else if (write_slot_ff == read_slot_ff) begin
                  single_status_in = capture_ff ? STATUS_EMPTY : STATUS_SHUTDOWN;
                  state_in         = ST_SINGLE;
               end else begin
                  // pop the oldest slot
                  rd_slot_in   = read_slot_ff;
                  read_slot_in = read_next;
                  state_in     = ST_COUNT;
               end
            end
         end
         ST_COUNT: begin
            pkt_cnt_in = cnt_rd_ff;
            idx_in     = '0;
            if (cnt_rd_ff == '0) begin
               single_status_in = STATUS_EVENT;
               state_in         = ST_SINGLE;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            ev_re    = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = RSP_DATA_WIDTH'({cnt_ext[SIZE_WIDTH-1:0], ev_rd_ff});
               rsp_status_in = STATUS_EVENT;
               rsp_last_in   = last_event;
               if (last_event) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = ST_FETCH;
               end
            end
         end
         ST_SINGLE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '0;
               rsp_status_in = single_status_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // configuration write; enabling capture restarts the ring
      if (csr_wr_en) begin
         capture_in = csr_wr_data;
         if (csr_wr_data) begin
            write_slot_in = '0;
            read_slot_in  = '0;
            asm_cnt_in    = '0;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         capture_ff       <= 1'b0;
         write_slot_ff    <= '0;
         read_slot_ff     <= '0;
         rd_slot_ff       <= '0;
         asm_cnt_ff       <= '0;
         pkt_cnt_ff       <= '0;
         idx_ff           <= '0;
         single_status_ff <= STATUS_EVENT;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         capture_ff       <= capture_in;
         write_slot_ff    <= write_slot_in;
         read_slot_ff     <= read_slot_in;
         rd_slot_ff       <= rd_slot_in;
         asm_cnt_ff       <= asm_cnt_in;
         pkt_cnt_ff       <= pkt_cnt_in;
         idx_ff           <= idx_in;
         single_status_ff <= single_status_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import iefq_pkg::*;

   localparam int PKT_EVENTS    = PACKET_EVENTS_DEFAULT;
   localparam int RING_DEPTH    = RING_SLOTS_DEFAULT;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 400;
   localparam int RANDOM_TARGET = 195;

   typedef struct packed {
      logic        op;
      logic        from_target;
      logic        injected;
      logic [15:0] ev_type;
      logic [15:0] ev_code;
      logic [31:0] ev_value;
      logic [31:0] secs;
      logic [19:0] micros;
   } request_type;

   typedef struct packed {
      logic [15:0] ev_type;
      logic [15:0] ev_code;
      logic [31:0] ev_value;
      logic [31:0] secs;
      logic [19:0] micros;
   } event_rec_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] ev_type;
      logic [15:0] ev_code;
      logic [31:0] ev_value;
      logic [31:0] secs;
      logic [19:0] micros;
      logic [3:0]  size;
      logic        is_last;
   } reply_type;

   typedef struct {
      logic        cfg_row;
      logic        cfg_value;
      request_type req;
      logic        typed;
      reply_type   typed_reply;
   } directed_row_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic                      csr_wr_data;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata;
   logic [REQ_USER_WIDTH-1:0] req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [RSP_USER_WIDTH-1:0] rsp_tuser;
   logic                      rsp_tlast;

   // Shadow copy of the packet ring and the packet under assembly
   event_rec_type ring_events [RING_DEPTH][PKT_EVENTS];
   int unsigned   ring_counts [RING_DEPTH];
   event_rec_type building [PKT_EVENTS];
   int unsigned   wr_slot;
   int unsigned   rd_slot;
   int unsigned   fill_count;
   logic          capture_on;

   reply_type        awaited_replies[$];
   directed_row_type directed_rows[$];
   int               fail_count    = 0;
   int               sent_count    = 0;
   logic             steady        = 1'b0;
   logic             long_hold_req = 1'b0;

   input_event_frame_queue u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic reply_type empty_reply(input status_type s);
      reply_type r;
      r = '0;
      r.status = s;
      r.is_last = 1'b1;
      return r;
   endfunction

   function automatic request_type make_event(input logic target, input logic inj,
                                              input logic [15:0] typ, input logic [15:0] code,
                                              input logic [31:0] value, input logic [31:0] secs,
                                              input logic [19:0] micros);
      request_type it;
      it.op = OP_EVENT;
      it.from_target = target;
      it.injected = inj;
      it.ev_type = typ;
      it.ev_code = code;
      it.ev_value = value;
      it.secs = secs;
      it.micros = micros;
      return it;
   endfunction

   function automatic request_type random_event(input logic target, input logic inj,
                                                input logic allow_sync);
      request_type it;
      it.op = OP_EVENT;
      it.from_target = target;
      it.injected = inj;
      it.ev_type = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
      it.ev_code = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
      it.ev_value = $urandom;
      it.secs = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : 32'($urandom);
      it.micros = ($urandom_range(0, 4) == 0) ? 20'($urandom) : 20'($urandom_range(0, 999999));
      // keep packet bodies free of accidental sync reports
      if (!allow_sync && it.ev_type == EV_SYN && it.ev_code == SYNC_CODE)
         it.ev_code = 16'd1;
      return it;
   endfunction

   function automatic request_type sync_event();
      request_type it;
      it = random_event(1'b1, 1'b0, 1'b1);
      it.ev_type = EV_SYN;
      it.ev_code = SYNC_CODE;
      return it;
   endfunction

   function automatic request_type random_read();
      request_type it;
      it = random_event(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
      it.op = OP_READ;
      return it;
   endfunction

   // Advance the shadow ring by one request and queue the replies it owes
   function automatic void model_request(input request_type it);
      event_rec_type rec;
      reply_type     r;
      int unsigned   slot;
      int unsigned   nxt;
      int unsigned   cnt;
      if (it.op == OP_EVENT) begin
         if (!it.from_target || it.injected || !capture_on) return;
         rec = '{it.ev_type, it.ev_code, it.ev_value, it.secs, it.micros};
         if (fill_count < PKT_EVENTS) begin
            building[fill_count] = rec;
            fill_count++;
         end
         if ((it.ev_type == EV_SYN && it.ev_code == SYNC_CODE) || fill_count >= PKT_EVENTS) begin
            // commit the packet, dropping the oldest one when the ring is full
            nxt = (wr_slot + 1) % RING_DEPTH;
            if (nxt == rd_slot) rd_slot = (rd_slot + 1) % RING_DEPTH;
            for (int i = 0; i < PKT_EVENTS; i++) ring_events[wr_slot][i] = building[i];
            ring_counts[wr_slot] = fill_count;
            wr_slot = nxt;
            fill_count = 0;
         end
         return;
      end
      if (wr_slot == rd_slot) begin
         awaited_replies.push_back(empty_reply(capture_on ? STATUS_EMPTY : STATUS_SHUTDOWN));
         return;
      end
      slot = rd_slot;
      cnt = ring_counts[slot];
      if (cnt > PKT_EVENTS) cnt = PKT_EVENTS;
      rd_slot = (slot + 1) % RING_DEPTH;
      // an empty packet answers with a single blank event
      if (cnt == 0) begin
         awaited_replies.push_back(empty_reply(STATUS_EVENT));
         return;
      end
      for (int i = 0; i < cnt; i++) begin
         rec = ring_events[slot][i];
         r.status = STATUS_EVENT;
         r.ev_type = rec.ev_type;
         r.ev_code = rec.ev_code;
         r.ev_value = rec.ev_value;
         r.secs = rec.secs;
         r.micros = rec.micros;
         r.size = cnt[3:0];
         r.is_last = (i + 1 == cnt);
         awaited_replies.push_back(r);
      end
   endfunction

   // Offer one request after a random gap (none in steady mode) and hold it until taken
   task automatic send_request(input request_type it);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {it.injected, it.from_target, it.op};
      req_tdata  <= {{(REQ_DATA_WIDTH - EVENT_BITS){1'b0}}, it.micros, it.secs, it.ev_value,
                     it.ev_code, it.ev_type};
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   task automatic issue(input request_type it);
      send_request(it);
      sent_count++;
      model_request(it);
   endtask

   // Write capture_enable once the block has gone quiet
   task automatic write_capture(input logic enable);
      req_tvalid <= 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= enable;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      capture_on = enable;
      if (enable) begin
         wr_slot = 0;
         rd_slot = 0;
         fill_count = 0;
      end
   endtask

   function automatic void add_request(input request_type it, input logic typed,
                                       input reply_type reply);
      directed_row_type row;
      row.cfg_row = 1'b0;
      row.cfg_value = 1'b0;
      row.req = it;
      row.typed = typed;
      row.typed_reply = reply;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_config(input logic value);
      directed_row_type row;
      row.cfg_row = 1'b1;
      row.cfg_value = value;
      row.req = '0;
      row.typed = 1'b0;
      row.typed_reply = '0;
      directed_rows.push_back(row);
   endfunction

   // Response sink: random stalls, plus one long hold-off on request
   initial begin : response_sink
      int stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!steady && $urandom_range(0, 99) < 25) begin
            stall_left = pick_gap();
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compare each accepted response with the oldest owed reply
   always @(posedge clock) begin : response_check
      reply_type got;
      reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status   = status_type'(rsp_tuser);
         got.ev_type  = rsp_tdata[15:0];
         got.ev_code  = rsp_tdata[31:16];
         got.ev_value = rsp_tdata[63:32];
         got.secs     = rsp_tdata[95:64];
         got.micros   = rsp_tdata[115:96];
         got.size     = rsp_tdata[119:116];
         got.is_last  = rsp_tlast;
         if (awaited_replies.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected response: st=%0d ty=%h cd=%h last=%b",
                        got.status, got.ev_type, got.ev_code, got.is_last);
         end else begin
            want = awaited_replies.pop_front();
            if (got.status !== want.status || got.ev_type !== want.ev_type ||
                got.ev_code !== want.ev_code || got.ev_value !== want.ev_value ||
                got.secs !== want.secs || got.micros !== want.micros ||
                got.size !== want.size || got.is_last !== want.is_last) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("mismatch exp: st=%0d ty=%h cd=%h val=%0d s=%h us=%h sz=%0d last=%b",
                           want.status, want.ev_type, want.ev_code, $signed(want.ev_value),
                           want.secs, want.micros, want.size, want.is_last);
                  $display("         got: st=%0d ty=%h cd=%h val=%0d s=%h us=%h sz=%0d last=%b",
                           got.status, got.ev_type, got.ev_code, $signed(got.ev_value),
                           got.secs, got.micros, got.size, got.is_last);
               end
            end
         end
      end
   end

   initial begin : stimulus
      int phase;
      int budget;
      int roll;
      int n;
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= 1'b0;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= '0;
      wr_slot = 0;
      rd_slot = 0;
      fill_count = 0;
      capture_on = 1'b0;

      // Directed rows: empty-ring statuses are typed in, packets go through the predictor
      add_request(random_read(), 1'b1, empty_reply(STATUS_SHUTDOWN));
      add_request(make_event(1'b1, 1'b0, 16'd1, 16'd2, 32'd3, 32'd4, 20'd5), 1'b0, '0);
      add_request(random_read(), 1'b1, empty_reply(STATUS_SHUTDOWN));
      add_config(1'b1);
      add_request(random_read(), 1'b1, empty_reply(STATUS_EMPTY));
      add_request(make_event(1'b0, 1'b0, 16'd1, 16'd1, 32'd9, 32'd9, 20'd9), 1'b0, '0);
      add_request(make_event(1'b1, 1'b1, EV_SYN, SYNC_CODE, 32'd7, 32'd7, 20'd7), 1'b0, '0);
      add_request(make_event(1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                             20'hFFFFF), 1'b0, '0);
      add_request(make_event(1'b1, 1'b0, EV_SYN, 16'd1, 32'h8000_0000, 32'd0, 20'd0),
                  1'b0, '0);
      add_request(make_event(1'b1, 1'b0, 16'd1, SYNC_CODE, 32'hFFFF_FFFF, 32'd1, 20'd999999),
                  1'b0, '0);
      add_request(make_event(1'b1, 1'b0, EV_SYN, SYNC_CODE, 32'd0, 32'd2, 20'd3), 1'b0, '0);
      add_request(random_read(), 1'b0, '0);
      add_request(random_read(), 1'b1, empty_reply(STATUS_EMPTY));
      // a full packet commits without a sync report
      for (int i = 0; i < PKT_EVENTS; i++)
         add_request(make_event(1'b1, 1'b0, 16'd3, 16'(i + 1), 32'(i), 32'(100 + i), 20'(i)),
                     1'b0, '0);
      add_request(make_event(1'b1, 1'b0, EV_SYN, SYNC_CODE, 32'd5, 32'd6, 20'd7), 1'b0, '0);
      add_request(random_read(), 1'b0, '0);
      add_request(random_read(), 1'b0, '0);
      add_config(1'b0);
      add_request(make_event(1'b1, 1'b0, EV_SYN, SYNC_CODE, 32'd1, 32'd1, 20'd1), 1'b0, '0);
      add_request(random_read(), 1'b1, empty_reply(STATUS_SHUTDOWN));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[k]) begin
         if (directed_rows[k].cfg_row) begin
            write_capture(directed_rows[k].cfg_value);
         end else begin
            send_request(directed_rows[k].req);
            if (directed_rows[k].typed) awaited_replies.push_back(directed_rows[k].typed_reply);
            else model_request(directed_rows[k].req);
         end
      end

      // Random phases: capture on, off, on without idling, and so on
      phase = 0;
      while (sent_count < RANDOM_TARGET) begin
         write_capture(phase % 3 != 1);
         steady = (phase == 2);
         if (phase == 1) long_hold_req = 1'b1;
         budget = sent_count + $urandom_range(30, 45);
         while (sent_count < budget) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
               // well-formed packet, usually closed by a sync report
               n = $urandom_range(1, 9);
               repeat (n) issue(random_event(1'b1, 1'b0, 1'b0));
               if ($urandom_range(0, 4) != 0) issue(sync_event());
            end else if (roll < 50) begin
               // flood the ring with one-event packets so the oldest get dropped
               repeat ($urandom_range(16, 19)) issue(sync_event());
            end else if (roll < 80) begin
               issue(random_read());
            end else if (roll < 90) begin
               issue(random_event(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1));
            end else begin
               repeat (3) issue(random_read());
            end
         end
         phase++;
      end

      // Drain the owed replies, then let the block settle
      req_tvalid <= 1'b0;
      steady = 1'b0;
      n = 0;
      while (awaited_replies.size() != 0 && n < 100000) begin
         @(posedge clock);
         n++;
      end
      repeat (20) @(posedge clock);
      if (awaited_replies.size() != 0) begin
         fail_count++;
         $display("%0d responses never arrived", awaited_replies.size());
      end
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
